>>> rtl/ille_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ille_pkg
// Shared sizes, codes, types and helpers of the linked list engine.
// ----------------------------------------------------------------------------
package ille_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 56;
  localparam int SLOT_BITS  = 11;
  localparam int CMD_BITS   = 2;
  localparam int STAT_BITS  = 2;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int CMP_BITS   = SLOT_BITS + COUNT_BITS;

  typedef logic signed [SLOT_BITS-1:0] slot_t;
  typedef logic [COUNT_BITS-1:0]       count_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;
  typedef logic [VALUE_BITS-1:0]       value_t;
  typedef logic [CMD_BITS-1:0]         cmd_t;
  typedef logic [STAT_BITS-1:0]        stat_t;

  localparam slot_t SLOT_NONE = '1;

  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;
  localparam cmd_t CMD_WALK   = 2'd3;

  localparam stat_t ST_OK     = 2'd0;
  localparam stat_t ST_FULL   = 2'd1;
  localparam stat_t ST_EMPTY  = 2'd2;
  localparam stat_t ST_BADPOS = 2'd3;

  typedef logic [3:0] uop_t;
  localparam uop_t UOP_NONE         = 4'd0;
  localparam uop_t UOP_LOAD         = 4'd1;
  localparam uop_t UOP_INS_HEAD     = 4'd2;
  localparam uop_t UOP_INS_READ     = 4'd3;
  localparam uop_t UOP_INS_LINK_NEW = 4'd4;
  localparam uop_t UOP_INS_LINK_POS = 4'd5;
  localparam uop_t UOP_REM_READ_POS = 4'd6;
  localparam uop_t UOP_REM_READ_HD  = 4'd7;
  localparam uop_t UOP_REM_READ_NXT = 4'd8;
  localparam uop_t UOP_REM_UNLINK   = 4'd9;
  localparam uop_t UOP_WALK_READ    = 4'd10;
  localparam uop_t UOP_WALK_ADVANCE = 4'd11;

  typedef logic [1:0] res_t;
  localparam res_t RES_NEW    = 2'd0;
  localparam res_t RES_FAIL   = 2'd1;
  localparam res_t RES_END    = 2'd2;
  localparam res_t RES_TARGET = 2'd3;

  typedef struct packed {
    logic  capture;
    uop_t  uop;
    logic  emit;
    res_t  res;
    stat_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic pos_head;
    logic full;
    logic pos_valid;
    logic head_valid;
    logic walk_valid;
    logic link_valid;
    logic out_free;
  } dp_status_t;

  function automatic logic valid_slot(input slot_t s, input count_t c);
    logic [CMP_BITS-1:0] sw;
    logic [CMP_BITS-1:0] cw;
    sw = CMP_BITS'($unsigned(s));
    cw = CMP_BITS'(c);
    return !s[SLOT_BITS-1] && (sw < cw);
  endfunction

endpackage

>>> rtl/ille_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ille_if
// Valid/ready channels of the linked list engine: items, results, config.
// ----------------------------------------------------------------------------
interface ille_item_if;
  logic                  valid;
  logic                  ready;
  ille_pkg::cmd_t        cmd;
  ille_pkg::slot_t       position;
  ille_pkg::value_t      node_value;
  ille_pkg::slot_t       link;
  logic                  restart;

  modport source (output valid, cmd, position, node_value, link, restart, input ready);
  modport sink   (input valid, cmd, position, node_value, link, restart, output ready);
endinterface

interface ille_result_if;
  logic                  valid;
  logic                  ready;
  ille_pkg::slot_t       slot;
  ille_pkg::value_t      out_value;
  ille_pkg::stat_t       status;
  logic                  list_end;

  modport source (output valid, slot, out_value, status, list_end, input ready);
  modport sink   (input valid, slot, out_value, status, list_end, output ready);
endinterface

interface ille_cfg_if;
  logic                  valid;
  logic                  ready;
  ille_pkg::slot_t       initial_head;

  modport source (output valid, initial_head, input ready);
  modport sink   (input valid, initial_head, output ready);
endinterface

>>> rtl/indexed_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Singly linked list in a 1024-slot node store: load, insert, remove, walk.
// ----------------------------------------------------------------------------
// One item is handled at a time; a new item is taken once the previous one
// has written its result beat, which may still wait at the output. Node store
// reads are registered. After capture, load, insert at head, a walk step at
// the end of the list and the store full, bad position and empty head cases
// end in decode; a walk step reads, then advances; remove at head reads the
// head, then unlinks; remove after a node reads it, then its successor
// (failing if it has none), then unlinks; insert after a node reads it,
// writes the new node, then links it. A taken output beat register stalls
// the result step, and a walk step waits for it before its first read. The
// initial_head register is to be written through its own channel only while
// the block is idle, which the block leaves to the user; cfg is always ready.
module indexed_linked_list_engine (
  input  logic         clk,
  input  logic         rst,
  ille_item_if.sink    item,
  ille_result_if.source result,
  ille_cfg_if.sink     cfg
);

  ille_pkg::dp_cmd_t    ctl;
  ille_pkg::dp_status_t stat;
  logic                 item_ready;

  assign item.ready = item_ready;
  assign cfg.ready  = 1'b1;

  ille_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  ille_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cmd        (item.cmd),
    .position   (item.position),
    .node_value (item.node_value),
    .link       (item.link),
    .restart    (item.restart),
    .cfg_write  (cfg.valid),
    .cfg_data   (cfg.initial_head),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .slot       (result.slot),
    .out_value  (result.out_value),
    .status     (result.status),
    .list_end   (result.list_end)
  );

endmodule

>>> rtl/ille_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ille_datapath
// Node store memories, list registers, item capture and result register.
// ----------------------------------------------------------------------------
module ille_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ille_pkg::dp_cmd_t     ctl,
  output ille_pkg::dp_status_t  stat,
  input  ille_pkg::cmd_t        cmd,
  input  ille_pkg::slot_t       position,
  input  ille_pkg::value_t      node_value,
  input  ille_pkg::slot_t       link,
  input  logic                  restart,
  input  logic                  cfg_write,
  input  ille_pkg::slot_t       cfg_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ille_pkg::slot_t       slot,
  output ille_pkg::value_t      out_value,
  output ille_pkg::stat_t       status,
  output logic                  list_end
);

  ille_pkg::slot_t  link_mem [ille_pkg::DEPTH];
  ille_pkg::value_t value_mem [ille_pkg::DEPTH];

  ille_pkg::cmd_t   item_cmd;
  ille_pkg::slot_t  item_pos;
  ille_pkg::value_t item_val;
  ille_pkg::slot_t  item_link;
  logic             item_restart;

  ille_pkg::count_t slot_count;
  ille_pkg::slot_t  head_slot;
  ille_pkg::slot_t  walk_cursor;
  ille_pkg::slot_t  initial_head;
  ille_pkg::slot_t  target;
  ille_pkg::slot_t  link_rd;
  ille_pkg::value_t value_rd;

  ille_pkg::slot_t  walk_pick;
  ille_pkg::slot_t  new_slot;
  ille_pkg::addr_t  count_addr;
  ille_pkg::addr_t  pos_addr;
  logic             pos_head;
  logic             out_free;

  logic             lwe;
  logic             vwe;
  logic             rde;
  ille_pkg::addr_t  waddr;
  ille_pkg::addr_t  raddr;
  ille_pkg::slot_t  lwdata;

  ille_pkg::slot_t  slot_next;
  ille_pkg::value_t value_next;
  ille_pkg::stat_t  status_next;
  logic             end_next;

  assign walk_pick  = item_restart ? head_slot : walk_cursor;
  assign new_slot   = ille_pkg::SLOT_BITS'(slot_count);
  assign count_addr = slot_count[ille_pkg::ADDR_BITS-1:0];
  assign pos_addr   = item_pos[ille_pkg::ADDR_BITS-1:0];
  assign pos_head   = (item_pos == ille_pkg::SLOT_NONE);
  assign out_free   = !res_valid || res_ready;

  always_comb begin
    stat.cmd        = item_cmd;
    stat.pos_head   = pos_head;
    stat.full       = (slot_count == ille_pkg::COUNT_BITS'(ille_pkg::DEPTH));
    stat.pos_valid  = ille_pkg::valid_slot(item_pos, slot_count);
    stat.head_valid = ille_pkg::valid_slot(head_slot, slot_count);
    stat.walk_valid = ille_pkg::valid_slot(walk_pick, slot_count);
    stat.link_valid = ille_pkg::valid_slot(link_rd, slot_count);
    stat.out_free   = out_free;
  end

  always_comb begin
    lwe    = 1'b0;
    vwe    = 1'b0;
    rde    = 1'b0;
    waddr  = count_addr;
    raddr  = pos_addr;
    lwdata = item_link;
    unique case (ctl.uop)
      ille_pkg::UOP_LOAD: begin
        lwe = 1'b1;
        vwe = 1'b1;
      end
      ille_pkg::UOP_INS_HEAD: begin
        lwe    = 1'b1;
        vwe    = 1'b1;
        lwdata = head_slot;
      end
      ille_pkg::UOP_INS_READ: begin
        rde = 1'b1;
      end
      ille_pkg::UOP_INS_LINK_NEW: begin
        lwe    = 1'b1;
        vwe    = 1'b1;
        lwdata = link_rd;
      end
      ille_pkg::UOP_INS_LINK_POS: begin
        lwe    = 1'b1;
        waddr  = pos_addr;
        lwdata = new_slot;
      end
      ille_pkg::UOP_REM_READ_POS: begin
        rde = 1'b1;
      end
      ille_pkg::UOP_REM_READ_HD: begin
        rde   = 1'b1;
        raddr = head_slot[ille_pkg::ADDR_BITS-1:0];
      end
      ille_pkg::UOP_REM_READ_NXT: begin
        rde   = 1'b1;
        raddr = link_rd[ille_pkg::ADDR_BITS-1:0];
      end
      ille_pkg::UOP_REM_UNLINK: begin
        lwe    = !pos_head;
        waddr  = pos_addr;
        lwdata = link_rd;
      end
      ille_pkg::UOP_WALK_READ: begin
        rde   = 1'b1;
        raddr = walk_pick[ille_pkg::ADDR_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  // node store, registered reads
  always_ff @(posedge clk) begin
    if (lwe) begin
      link_mem[waddr] <= lwdata;
    end
    if (rde) begin
      link_rd <= link_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      value_mem[waddr] <= item_val;
    end
    if (rde) begin
      value_rd <= value_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd     <= cmd;
      item_pos     <= position;
      item_val     <= node_value;
      item_link    <= link;
      item_restart <= restart;
    end
    unique case (ctl.uop)
      ille_pkg::UOP_REM_READ_HD:  target <= head_slot;
      ille_pkg::UOP_REM_READ_NXT: target <= link_rd;
      ille_pkg::UOP_WALK_READ:    target <= walk_pick;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= '0;
      head_slot    <= ille_pkg::SLOT_NONE;
      walk_cursor  <= ille_pkg::SLOT_NONE;
      initial_head <= ille_pkg::SLOT_NONE;
    end else begin
      if (cfg_write) begin
        initial_head <= cfg_data;
      end
      unique case (ctl.uop)
        ille_pkg::UOP_LOAD: begin
          slot_count <= slot_count + 1'b1;
          if (slot_count == '0) begin
            head_slot <= initial_head;
          end
        end
        ille_pkg::UOP_INS_HEAD: begin
          slot_count <= slot_count + 1'b1;
          head_slot  <= new_slot;
        end
        ille_pkg::UOP_INS_LINK_POS: begin
          slot_count <= slot_count + 1'b1;
        end
        ille_pkg::UOP_REM_UNLINK: begin
          if (pos_head) begin
            head_slot <= link_rd;
          end
        end
        ille_pkg::UOP_WALK_READ: begin
          walk_cursor <= walk_pick;
        end
        ille_pkg::UOP_WALK_ADVANCE: begin
          walk_cursor <= link_rd;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    slot_next   = ille_pkg::SLOT_NONE;
    value_next  = '0;
    status_next = ille_pkg::ST_OK;
    end_next    = 1'b0;
    unique case (ctl.res)
      ille_pkg::RES_NEW: begin
        slot_next = new_slot;
      end
      ille_pkg::RES_FAIL: begin
        status_next = ctl.res_status;
      end
      ille_pkg::RES_END: begin
        end_next = 1'b1;
      end
      ille_pkg::RES_TARGET: begin
        slot_next  = target;
        value_next = value_rd;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      slot      <= slot_next;
      out_value <= value_next;
      status    <= status_next;
      list_end  <= end_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> out_free)
    else $error("result written over an untaken beat");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= ille_pkg::COUNT_BITS'(ille_pkg::DEPTH))
    else $error("slot count beyond store depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (ctl.uop == ille_pkg::UOP_LOAD || ctl.uop == ille_pkg::UOP_INS_HEAD ||
     ctl.uop == ille_pkg::UOP_INS_LINK_POS) |=>
    slot_count == $past(slot_count) + 1'b1)
    else $error("slot count did not advance on node write");

endmodule

>>> rtl/ille_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ille_ctrl
// Sequencer of the linked list engine: decodes a captured item and steps
// the datapath through its node store reads and writes.
// ----------------------------------------------------------------------------
module ille_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  ille_pkg::dp_status_t  stat,
  output ille_pkg::dp_cmd_t     ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_INS_LINK = 3'd2;
  localparam logic [2:0] S_INS_POS  = 3'd3;
  localparam logic [2:0] S_REM_NEXT = 3'd4;
  localparam logic [2:0] S_REM_DONE = 3'd5;
  localparam logic [2:0] S_WALK     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    ctl.capture    = 1'b0;
    ctl.uop        = ille_pkg::UOP_NONE;
    ctl.emit       = 1'b0;
    ctl.res        = ille_pkg::RES_NEW;
    ctl.res_status = ille_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          ille_pkg::CMD_LOAD: begin
            if (stat.out_free) begin
              ctl.emit   = 1'b1;
              state_next = S_IDLE;
              if (stat.full) begin
                ctl.res        = ille_pkg::RES_FAIL;
                ctl.res_status = ille_pkg::ST_FULL;
              end else begin
                ctl.uop = ille_pkg::UOP_LOAD;
              end
            end
          end
          ille_pkg::CMD_INSERT: begin
            if (stat.full || (!stat.pos_head && !stat.pos_valid)) begin
              if (stat.out_free) begin
                ctl.emit       = 1'b1;
                ctl.res        = ille_pkg::RES_FAIL;
                ctl.res_status = stat.full ? ille_pkg::ST_FULL : ille_pkg::ST_BADPOS;
                state_next     = S_IDLE;
              end
            end else if (stat.pos_head) begin
              if (stat.out_free) begin
                ctl.uop    = ille_pkg::UOP_INS_HEAD;
                ctl.emit   = 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              ctl.uop    = ille_pkg::UOP_INS_READ;
              state_next = S_INS_LINK;
            end
          end
          ille_pkg::CMD_REMOVE: begin
            if (stat.pos_head) begin
              if (stat.head_valid) begin
                ctl.uop    = ille_pkg::UOP_REM_READ_HD;
                state_next = S_REM_DONE;
              end else if (stat.out_free) begin
                ctl.emit       = 1'b1;
                ctl.res        = ille_pkg::RES_FAIL;
                ctl.res_status = ille_pkg::ST_EMPTY;
                state_next     = S_IDLE;
              end
            end else if (stat.pos_valid) begin
              ctl.uop    = ille_pkg::UOP_REM_READ_POS;
              state_next = S_REM_NEXT;
            end else if (stat.out_free) begin
              ctl.emit       = 1'b1;
              ctl.res        = ille_pkg::RES_FAIL;
              ctl.res_status = ille_pkg::ST_BADPOS;
              state_next     = S_IDLE;
            end
          end
          ille_pkg::CMD_WALK: begin
            if (stat.out_free) begin
              ctl.uop = ille_pkg::UOP_WALK_READ;
              if (stat.walk_valid) begin
                state_next = S_WALK;
              end else begin
                ctl.emit   = 1'b1;
                ctl.res    = ille_pkg::RES_END;
                state_next = S_IDLE;
              end
            end
          end
        endcase
      end
      S_INS_LINK: begin
        ctl.uop    = ille_pkg::UOP_INS_LINK_NEW;
        state_next = S_INS_POS;
      end
      S_INS_POS: begin
        if (stat.out_free) begin
          ctl.uop    = ille_pkg::UOP_INS_LINK_POS;
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REM_NEXT: begin
        if (stat.link_valid) begin
          ctl.uop    = ille_pkg::UOP_REM_READ_NXT;
          state_next = S_REM_DONE;
        end else if (stat.out_free) begin
          ctl.emit       = 1'b1;
          ctl.res        = ille_pkg::RES_FAIL;
          ctl.res_status = ille_pkg::ST_EMPTY;
          state_next     = S_IDLE;
        end
      end
      S_REM_DONE: begin
        if (stat.out_free) begin
          ctl.uop    = ille_pkg::UOP_REM_UNLINK;
          ctl.emit   = 1'b1;
          ctl.res    = ille_pkg::RES_TARGET;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.out_free) begin
          ctl.uop    = ille_pkg::UOP_WALK_ADVANCE;
          ctl.emit   = 1'b1;
          ctl.res    = ille_pkg::RES_TARGET;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_capture_decode: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> state == S_DECODE)
    else $error("captured item not decoded next");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> state == S_IDLE)
    else $error("sequencer kept running after its result");

  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |-> !ctl.emit && ctl.uop == ille_pkg::UOP_NONE)
    else $error("datapath work issued during capture");

endmodule
